// File: rtl/fpdf_pkg.sv
// Shared types and constants for the fixed-point decimal formatter.
// No dependencies; imported by every module of the formatter.
package fpdf_pkg;

   // Number format
   localparam int VALUE_W     = 32;
   localparam int INT_W       = 16;
   localparam int FRAC_W      = 16;
   localparam int CHAR_W      = 7;
   localparam int DIG_W       = 4;
   localparam int FRAC_DIGITS = 6;
   localparam int INT_DIGITS  = 5;

   // Conversion runs for as many steps as the longer digit string
   localparam int CONV_STEPS = (FRAC_DIGITS > INT_DIGITS) ? FRAC_DIGITS : INT_DIGITS;
   localparam int CNT_W      = $clog2(CONV_STEPS);
   localparam int IIDX_W     = $clog2(INT_DIGITS);
   localparam int FIDX_W     = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;

   // Decimal scale of the fraction, 10 to the FRAC_DIGITS
   function automatic longint pow10(input int n);
      longint p;
      p = 1;
      for (int i = 0; i < n; i++) begin
         p = p * 10;
      end
      return p;
   endfunction

   localparam longint FRAC_SCALE = pow10(FRAC_DIGITS);
   localparam int     FPART_W    = $clog2(FRAC_SCALE);

   // Reciprocal divide-by-ten: q = (x * RECIP) >> SHIFT, exact for x below 2^width
   localparam int     INT_SHIFT   = INT_W + 4;
   localparam longint INT_RECIP   = ((64'd1 << INT_SHIFT) + 64'd9) / 64'd10;
   localparam int     FRAC_SHIFT  = FPART_W + 4;
   localparam longint FRAC_RECIP  = ((64'd1 << FRAC_SHIFT) + 64'd9) / 64'd10;

   // ASCII codes
   localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;
   localparam logic [CHAR_W-1:0] CH_POINT = 7'h2e;

   // Character source select
   localparam logic [1:0] SEL_MINUS = 2'd0;
   localparam logic [1:0] SEL_INT   = 2'd1;
   localparam logic [1:0] SEL_POINT = 2'd2;
   localparam logic [1:0] SEL_FRAC  = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic             load;
      logic             mul;
      logic             conv;
      logic             emit;
      logic [1:0]       sel;
      logic             last;
      logic [CNT_W-1:0] idx;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic             neg;
      logic [CNT_W-1:0] nd;
      logic             out_free;
   } sts_type;

endpackage

// File: rtl/fpdf_dp.sv
// Datapath of the decimal formatter: magnitude, fraction scaling, two
// divide-by-ten units, digit registers and the output register. Uses fpdf_pkg.
module fpdf_dp
   import fpdf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic signed [VALUE_W-1:0] req_value,
   input  cmd_type                   cmd,
   output sts_type                   sts,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [CHAR_W-1:0]         rsp_text_char,
   output logic                      rsp_last_char
);

   logic                 neg_ff, neg_in;
   logic [INT_W-1:0]     iwork_ff, iwork_in;
   logic [FRAC_W-1:0]    frac_ff, frac_in;
   logic [FPART_W-1:0]   fwork_ff, fwork_in;
   logic [CNT_W-1:0]     nd_ff, nd_in;
   logic [DIG_W-1:0]     idig_ff [INT_DIGITS];
   logic [DIG_W-1:0]     fdig_ff [FRAC_DIGITS];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    text_ff, text_in;
   logic                 last_ff, last_in;

   logic [VALUE_W-1:0]            mag;
   logic [FRAC_W+FPART_W-1:0]     fscale_prod;
   logic [INT_SHIFT+INT_W-1:0]    iprod;
   logic [INT_W-1:0]              iquot, itimes10;
   logic [DIG_W-1:0]              irem;
   logic [FRAC_SHIFT+FPART_W-1:0] fprod;
   logic [FPART_W-1:0]            fquot, ftimes10;
   logic [DIG_W-1:0]              frem;
   logic [DIG_W-1:0]              idig_rd, fdig_rd;
   logic                          out_free;

   // Take the magnitude; the most negative word wraps to 0x80000000 = 32768.0
   assign mag = req_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(req_value))
                                     : VALUE_W'(req_value);

   // Scale the fraction to FRAC_DIGITS decimal places, truncated
   assign fscale_prod = (FRAC_W+FPART_W)'(frac_ff)
                      * (FRAC_W+FPART_W)'(FRAC_SCALE[FPART_W-1:0]);

   // Divide the integer part by ten
   assign iprod    = (INT_SHIFT+INT_W)'(iwork_ff)
                   * (INT_SHIFT+INT_W)'(INT_RECIP[INT_W:0]);
   assign iquot    = iprod[INT_SHIFT+INT_W-1:INT_SHIFT];
   assign itimes10 = (iquot << 3) + (iquot << 1);
   assign irem     = DIG_W'(iwork_ff - itimes10);

   // Divide the scaled fraction by ten
   assign fprod    = (FRAC_SHIFT+FPART_W)'(fwork_ff)
                   * (FRAC_SHIFT+FPART_W)'(FRAC_RECIP[FPART_W:0]);
   assign fquot    = fprod[FRAC_SHIFT+FPART_W-1:FRAC_SHIFT];
   assign ftimes10 = (fquot << 3) + (fquot << 1);
   assign frem     = DIG_W'(fwork_ff - ftimes10);

   // Load, scale and step the working values
   always_comb begin
      neg_in   = neg_ff;
      iwork_in = iwork_ff;
      frac_in  = frac_ff;
      fwork_in = fwork_ff;
      nd_in    = nd_ff;
      if (cmd.load) begin
         neg_in   = req_value[VALUE_W-1];
         iwork_in = mag[VALUE_W-1:FRAC_W];
         frac_in  = mag[FRAC_W-1:0];
      end else if (cmd.mul) begin
         fwork_in = fscale_prod[FRAC_W+FPART_W-1:FRAC_W];
      end else if (cmd.conv) begin
         iwork_in = iquot;
         fwork_in = fquot;
         if ((cmd.idx == '0) || (iwork_ff != '0)) begin
            nd_in = cmd.idx + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      iwork_ff <= iwork_in;
      frac_ff  <= frac_in;
      fwork_ff <= fwork_in;
      nd_ff    <= nd_in;
   end

   // Store digits, least significant first
   always_ff @(posedge clock) begin
      if (cmd.conv && (int'(cmd.idx) < INT_DIGITS)) begin
         idig_ff[cmd.idx[IIDX_W-1:0]] <= irem;
      end
      if (cmd.conv && (int'(cmd.idx) < FRAC_DIGITS)) begin
         fdig_ff[cmd.idx[FIDX_W-1:0]] <= frem;
      end
   end

   assign idig_rd = idig_ff[cmd.idx[IIDX_W-1:0]];
   assign fdig_rd = fdig_ff[cmd.idx[FIDX_W-1:0]];

   // Select the character for an emit
   always_comb begin
      case (cmd.sel)
         SEL_MINUS: text_in = CH_MINUS;
         SEL_INT:   text_in = CH_ZERO + CHAR_W'(idig_rd);
         SEL_POINT: text_in = CH_POINT;
         SEL_FRAC:  text_in = CH_ZERO + CHAR_W'(fdig_rd);
         default:   text_in = CH_POINT;
      endcase
   end

   // Output register: load on emit, drop when taken
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      last_in      = last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         last_in      = cmd.last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         text_ff <= text_in;
      end
      last_ff <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = text_ff;
   assign rsp_last_char = last_ff;

   assign sts.neg      = neg_ff;
   assign sts.nd       = nd_ff;
   assign sts.out_free = out_free;

endmodule

// File: rtl/fpdf_ctrl.sv
// Controller of the decimal formatter: sequences load, scaling, digit
// conversion and character emission. Uses fpdf_pkg.
module fpdf_ctrl
   import fpdf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_CONV = 3'd2;
   localparam logic [2:0] ST_SIGN = 3'd3;
   localparam logic [2:0] ST_INT  = 3'd4;
   localparam logic [2:0] ST_DOT  = 3'd5;
   localparam logic [2:0] ST_FRAC = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Advance the sequence
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.idx  = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            cnt_in   = '0;
            state_in = ST_CONV;
         end
         ST_CONV: begin
            cmd.conv = 1'b1;
            if (int'(cnt_ff) == CONV_STEPS - 1) begin
               state_in = ST_SIGN;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_SIGN: begin
            cmd.sel = SEL_MINUS;
            if (!sts.neg || sts.out_free) begin
               cmd.emit = sts.neg;
               cnt_in   = sts.nd - CNT_W'(1);
               state_in = ST_INT;
            end
         end
         ST_INT: begin
            cmd.sel = SEL_INT;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (cnt_ff == '0) begin
                  state_in = ST_DOT;
               end else begin
                  cnt_in = cnt_ff - CNT_W'(1);
               end
            end
         end
         ST_DOT: begin
            cmd.sel = SEL_POINT;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cnt_in   = CNT_W'(FRAC_DIGITS - 1);
               state_in = ST_FRAC;
            end
         end
         ST_FRAC: begin
            cmd.sel  = SEL_FRAC;
            cmd.last = (cnt_ff == '0);
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (cnt_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   // Never overwrite a character still waiting at the output
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("emit while output register occupied");

   // The flagged character ends the request
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |=> (state_ff == ST_IDLE))
      else $error("sequence did not end after last character");

   // Integer digit count lies in 1..INT_DIGITS once conversion is done
   a_nd_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIGN) |-> ((sts.nd != '0) && (int'(sts.nd) <= INT_DIGITS)))
      else $error("integer digit count out of range");

   // The last flag appears only on a fraction digit
   a_last_frac: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |-> (cmd.sel == SEL_FRAC))
      else $error("last flag on a non-fraction character");

endmodule

// File: rtl/fixed_point_decimal_formatter_unit.sv
// Top level of the signed 16.16 fixed-point to decimal ASCII formatter.
// Instantiates fpdf_ctrl and fpdf_dp; uses fpdf_pkg.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   req_value (signed 32)
//   rsp_      out        rsp_valid/rsp_stall   rsp_text_char (7), rsp_last_char (1)
//
// One request at a time: after acceptance the fraction is scaled and the
// divide-by-ten units run, then the characters are emitted in order: the
// sign if negative, the integer digits, the point and the fraction digits.
// Reset is synchronous and active high and clears only control state. An
// output stall holds the sequence; the output register frees the block to
// take the next request while the final character waits.
module fixed_point_decimal_formatter_unit
   import fpdf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [CHAR_W-1:0]         rsp_text_char,
   output logic                      rsp_last_char
);

   cmd_type cmd;
   sts_type sts;

   // Sequence the request
   fpdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Convert and emit characters
   fpdf_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for fixed_point_decimal_formatter_unit.
// Depends on fpdf_pkg and the formatter RTL. It predicts the ASCII text of each
// signed 16.16 request and checks every character and its last flag in order.
module tb_top;
   import fpdf_pkg::*;

   localparam int RANDOM_REQUESTS = 344;
   localparam int HOLD_CYCLES     = 300;
   localparam int QUIET_LIMIT     = 3000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int GAP_PERCENT     = 12;

   typedef logic [CHAR_W-1:0] char_queue_type[$];

   typedef struct packed {
      logic [CHAR_W-1:0] text_char;
      logic              last_char;
   } text_char_type;

   // Directed request; an empty text means the predictor supplies the characters
   typedef struct {
      logic [VALUE_W-1:0] value;
      string              text;
   } directed_row_type;

   localparam int DIRECTED_N = 26;

   directed_row_type directed_rows [DIRECTED_N] = '{
      '{32'h0000_0000, "0.000000"},
      '{32'h8000_0000, "-32768.000000"},
      '{32'h7fff_ffff, "32767.999984"},
      '{32'hffff_ffff, "-0.000015"},
      '{32'h0000_0001, "0.000015"},
      '{32'h0001_0000, "1.000000"},
      '{32'hffff_0000, "-1.000000"},
      '{32'h0000_8000, "0.500000"},
      '{32'h7fff_0000, "32767.000000"},
      '{32'h8000_0001, "-32767.999984"},
      '{32'h0000_ffff, "0.999984"},
      '{32'h0009_ffff, ""},
      '{32'h000a_0000, ""},
      '{32'h0063_0001, ""},
      '{32'h0064_0000, ""},
      '{32'h03e7_8000, ""},
      '{32'h03e8_0000, ""},
      '{32'h270f_4000, ""},
      '{32'h2710_0000, ""},
      '{32'hfff6_0000, ""},
      '{32'hd8f0_0000, ""},
      '{32'h1234_5678, ""},
      '{32'hedcb_a988, ""},
      '{32'h0000_0011, ""},
      '{32'h0003_243f, ""},
      '{32'hffff_8000, ""}
   };

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [VALUE_W-1:0] req_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [CHAR_W-1:0]         rsp_text_char;
   logic                      rsp_last_char;

   text_char_type expected_text[$];
   int            error_count    = 0;
   int            request_count  = 0;
   int            negative_count = 0;
   int            char_count     = 0;
   bit            gaps_enabled   = 1'b1;
   bit            hold_pending   = 1'b0;

   fixed_point_decimal_formatter_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      error_count++;
   endtask

   // Decimal text of a signed 16.16 word, most negative value taken as 32768.0
   function automatic char_queue_type format_fixed_point(input logic [VALUE_W-1:0] word);
      char_queue_type     chars;
      char_queue_type     digits;
      logic [VALUE_W-1:0] mag;
      logic [INT_W-1:0]   ipart;
      logic [63:0]        fpart;
      chars = {};
      digits = {};
      mag = word[VALUE_W-1] ? (32'd0 - word) : word;
      ipart = mag[VALUE_W-1:FRAC_W];
      fpart = (64'(mag[FRAC_W-1:0]) * 64'(FRAC_SCALE)) >> FRAC_W;
      if (word[VALUE_W-1]) begin
         chars.push_back(CH_MINUS);
      end
      // integer digits, no leading zeros, at least one
      do begin
         digits.push_front(CH_ZERO + CHAR_W'(ipart % 10));
         ipart = INT_W'(ipart / 10);
      end while (ipart != 0);
      chars = {chars, digits};
      chars.push_back(CH_POINT);
      // fraction digits, leading zeros kept
      digits = {};
      for (int k = 0; k < FRAC_DIGITS; k++) begin
         digits.push_front(CH_ZERO + CHAR_W'(fpart % 10));
         fpart = fpart / 10;
      end
      return {chars, digits};
   endfunction

   function automatic char_queue_type string_to_chars(input string text);
      char_queue_type chars;
      byte            b;
      chars = {};
      for (int i = 0; i < text.len(); i++) begin
         b = text[i];
         chars.push_back(b[CHAR_W-1:0]);
      end
      return chars;
   endfunction

   // Offer one request, holding it until the block takes it
   task automatic drive_request(input logic [VALUE_W-1:0] value,
                                input char_queue_type text);
      bit taken;
      while (gaps_enabled && $urandom_range(0, 99) < GAP_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do begin
         @(negedge clock);
         taken = !req_stall;
         if (taken) begin
            foreach (text[i]) begin
               expected_text.push_back('{text[i], i == text.size() - 1});
            end
            request_count++;
            if (value[VALUE_W-1]) begin
               negative_count++;
            end
         end
         @(posedge clock);
      end while (!taken);
   endtask

   // Random word shaped to hit every digit count, tiny fractions and the corners
   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] v;
      int                 digits;
      int                 top;
      case ($urandom_range(0, 6))
         0, 1: begin
            v = $urandom;
         end
         2: begin
            digits = $urandom_range(1, INT_DIGITS);
            top = (digits == 1) ? 9 : (digits == 2) ? 99 : (digits == 3) ? 999 :
                  (digits == 4) ? 9999 : 32767;
            v = {16'($urandom_range(0, top)), 16'($urandom)};
         end
         3: begin
            v = 32'($urandom_range(0, 65535));
         end
         4: begin
            v = {16'($urandom), 16'h0000};
         end
         5: begin
            v = {16'($urandom_range(0, 32767)), ($urandom_range(0, 1) ? 16'hffff : 16'h0001)};
         end
         default: begin
            case ($urandom_range(0, 3))
               0: v = 32'h8000_0000;
               1: v = 32'h7fff_ffff;
               2: v = 32'hffff_ffff;
               default: v = 32'h8000_0000 + 32'($urandom_range(1, 255));
            endcase
         end
      endcase
      // flip sign on half of the shaped cases
      if ($urandom_range(0, 1) && v != 32'h8000_0000) begin
         v = 32'd0 - v;
      end
      return v;
   endfunction

   // Receiver: random stalls, one long hold when asked
   initial begin
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            for (int i = 0; i < HOLD_CYCLES; i++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end else begin
            rsp_stall <= gaps_enabled && ($urandom_range(0, 99) < GAP_PERCENT);
            @(posedge clock);
         end
      end
   end

   // Check each accepted character against the oldest expectation
   always @(negedge clock) begin
      text_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         char_count++;
         if (expected_text.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                      rsp_text_char, rsp_last_char));
         end else begin
            want = expected_text.pop_front();
            if (rsp_text_char !== want.text_char) begin
               report_mismatch($sformatf("text_char got 0x%02h want 0x%02h",
                                         rsp_text_char, want.text_char));
            end
            if (rsp_last_char !== want.last_char) begin
               report_mismatch($sformatf("last_char got %0b want %0b on char 0x%02h",
                                         rsp_last_char, want.last_char, want.text_char));
            end
         end
      end
   end

   // Watchdog: end the run after too many cycles without any handshake
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(negedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Timeout: no handshake for %0d cycles, %0d characters outstanding",
               QUIET_LIMIT, expected_text.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Stimulus: reset, directed table, then random requests
   initial begin
      char_queue_type row_text;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_value <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].text.len() != 0) begin
            row_text = string_to_chars(directed_rows[i].text);
         end else begin
            row_text = format_fixed_point(directed_rows[i].value);
         end
         drive_request(directed_rows[i].value, row_text);
      end

      // random part; a stretch without gaps and one long receiver hold
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         logic [VALUE_W-1:0] v;
         gaps_enabled = !(n >= 40 && n < 140);
         if (n == 200) begin
            hold_pending = 1'b1;
         end
         v = pick_value();
         drive_request(v, format_fixed_point(v));
      end
      req_valid <= 1'b0;

      // drain
      while (expected_text.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests (%0d directed, %0d negative), %0d characters checked",
               request_count, DIRECTED_N, negative_count, char_count);
      $display("Included a %0d-cycle receiver hold and a gap-free stretch", HOLD_CYCLES);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
